FILE: hdl/hpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

  // Block geometry
  localparam int MAX_ELEMENTS = 16;
  localparam int DATA_WIDTH   = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int PTR_W        = CNT_W + 1;

  // Output tdata layout: value_res, position, split_index, zero fill
  localparam int OUT_FIELDS_W = DATA_WIDTH + IDX_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [11:0] {
    ST_LOAD  = 12'b0000_0000_0001,
    ST_PRD   = 12'b0000_0000_0010,
    ST_PIV   = 12'b0000_0000_0100,
    ST_OUTER = 12'b0000_0000_1000,
    ST_LREQ  = 12'b0000_0001_0000,
    ST_LCHK  = 12'b0000_0010_0000,
    ST_RREQ  = 12'b0000_0100_0000,
    ST_RCHK  = 12'b0000_1000_0000,
    ST_DEC   = 12'b0001_0000_0000,
    ST_SWA   = 12'b0010_0000_0000,
    ST_SWB   = 12'b0100_0000_0000,
    ST_EWAIT = 12'b1000_0000_0000
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/hoare_partition_engine_unit.sv
// Load: one item per cycle into the element store; the item with tlast starts the partition.
// Partition: ST_PRD and ST_PIV fetch the pivot (element 0); each round then runs ST_OUTER,
// the scans (ST_LREQ/ST_LCHK, ST_RREQ/ST_RCHK), ST_DEC and, unless crossed, ST_SWA/ST_SWB.
// Emit: follows the final pointer check, one result per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) clears the sequencer, count, pointers and output valid;
// the element store is not cleared and only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none

module hoare_partition_engine_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [hpe_pkg::DATA_WIDTH-1:0]      in_tdata,   // [31:0] value
  input  wire logic                                in_tlast,   // is_last
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [hpe_pkg::OUT_TDATA_W-1:0]          out_tdata,  // value_res, position, split_index
  output logic                                     out_tlast   // is_last_res
);
  import hpe_pkg::*;

  // element store
  logic [DATA_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;

  // control and working registers
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        small_r, small_nxt;
  logic signed [PTR_W-1:0] large_r, large_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [DATA_WIDTH-1:0]   piv_r, piv_nxt;
  logic [DATA_WIDTH-1:0]   vl_r, vl_nxt;
  logic [DATA_WIDTH-1:0]   vr_r, vr_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [DATA_WIDTH-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0]      out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]      out_split_r, out_split_nxt;

  // helpers
  logic                  in_acc;
  logic                  out_free;
  logic [CNT_W-1:0]      small_p1;
  logic signed [PTR_W-1:0] large_m1;
  logic signed [PTR_W-1:0] small_s;
  logic                  cross_ok;
  logic                  emit_last;

  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign small_p1  = small_r + CNT_W'(1);
  assign large_m1  = large_r - PTR_W'(1);
  assign small_s   = $signed({1'b0, small_r});
  assign cross_ok  = small_s <= large_r;
  assign emit_last = ({1'b0, k_r} == (count_r - CNT_W'(1)));

  assign in_tready  = (state_r == ST_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_split_r, out_pos_r, out_value_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    small_nxt     = small_r;
    large_nxt     = large_r;
    k_nxt         = k_r;
    piv_nxt       = piv_r;
    vl_nxt        = vl_r;
    vr_nxt        = vr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_value_nxt = out_value_r;
    out_pos_nxt   = out_pos_r;
    out_split_nxt = out_split_r;
    rd_addr       = k_r;
    mem_we        = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = in_tdata;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          // store saturates: extra words are dropped
          if (count_r < CNT_W'(MAX_ELEMENTS)) begin
            mem_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_tlast) state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        rd_addr   = '0;
        state_nxt = ST_PIV;
      end
      ST_PIV: begin
        piv_nxt   = rdata_r;
        small_nxt = '0;
        large_nxt = $signed({1'b0, count_r}) - PTR_W'(1);
        state_nxt = ST_OUTER;
      end
      ST_OUTER: begin
        if (cross_ok) begin
          state_nxt = ST_LREQ;
        end else begin
          rd_addr   = '0;
          k_nxt     = '0;
          state_nxt = ST_EWAIT;
        end
      end
      // left scan: skip elements below the pivot
      ST_LREQ: begin
        if (small_r < count_r) begin
          rd_addr   = small_r[IDX_W-1:0];
          state_nxt = ST_LCHK;
        end else begin
          state_nxt = ST_RREQ;
        end
      end
      ST_LCHK: begin
        if ($signed(rdata_r) < $signed(piv_r)) begin
          small_nxt = small_p1;
          if (small_p1 < count_r) rd_addr = small_p1[IDX_W-1:0];
          else                    state_nxt = ST_RREQ;
        end else begin
          vl_nxt    = rdata_r;
          state_nxt = ST_RREQ;
        end
      end
      // right scan: skip elements above the pivot
      ST_RREQ: begin
        if (!large_r[PTR_W-1]) begin
          rd_addr   = large_r[IDX_W-1:0];
          state_nxt = ST_RCHK;
        end else begin
          state_nxt = ST_DEC;
        end
      end
      ST_RCHK: begin
        if ($signed(rdata_r) > $signed(piv_r)) begin
          large_nxt = large_m1;
          if (!large_m1[PTR_W-1]) rd_addr = large_m1[IDX_W-1:0];
          else                    state_nxt = ST_DEC;
        end else begin
          vr_nxt    = rdata_r;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = cross_ok ? ST_SWA : ST_OUTER;
      end
      // swap, one write per cycle
      ST_SWA: begin
        mem_we    = 1'b1;
        wr_addr   = small_r[IDX_W-1:0];
        wr_data   = vr_r;
        state_nxt = ST_SWB;
      end
      ST_SWB: begin
        mem_we    = 1'b1;
        wr_addr   = large_r[IDX_W-1:0];
        wr_data   = vl_r;
        small_nxt = small_p1;
        large_nxt = large_m1;
        state_nxt = ST_OUTER;
      end
      // emit: rdata_r holds element k; read k+1 as k leaves
      ST_EWAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rdata_r;
          out_pos_nxt   = k_r;
          out_split_nxt = small_r;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            count_nxt = '0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt   = k_r + IDX_W'(1);
            rd_addr = k_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      small_r     <= '0;
      large_r     <= '0;
      k_r         <= '0;
      piv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      small_r     <= small_nxt;
      large_r     <= large_nxt;
      k_r         <= k_nxt;
      piv_r       <= piv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vl_r        <= vl_nxt;
    vr_r        <= vr_nxt;
    out_last_r  <= out_last_nxt;
    out_value_r <= out_value_nxt;
    out_pos_r   <= out_pos_nxt;
    out_split_r <= out_split_nxt;
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS))
    else $error("element count above store depth");

  // the left pointer still holds the previous block's value until the pivot is taken
  a_small_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD && state_r != ST_PRD && state_r != ST_PIV |-> small_r <= count_r)
    else $error("left pointer past end of block");

  a_no_write_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EWAIT |-> !mem_we)
    else $error("store written during emit");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> state_r == ST_PRD)
    else $error("final item did not start partition");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import hpe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TARGET_ITEMS = 210;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;

  // One emitted element of a partitioned block
  typedef struct {
    logic signed [DATA_WIDTH-1:0] value;
    logic [IDX_W-1:0]             position;
    logic [CNT_W-1:0]             split;
    logic                         last;
  } element_res_t;

  // Keeps its own copy of the block store, partitions each closed block and
  // holds the emitted elements until the block sends them.
  class partition_scoreboard;
    logic signed [DATA_WIDTH-1:0] blk_store [MAX_ELEMENTS];
    int                           blk_count = 0;
    element_res_t                 partitioned_q [$];
    int                           items_in = 0;
    int                           errors = 0;

    // Hoare scan, first element as pivot; returns the left pointer's final value
    function int partition_block(int n);
      int                           lo;
      int                           hi;
      logic signed [DATA_WIDTH-1:0] piv;
      logic signed [DATA_WIDTH-1:0] tmp;
      lo  = 0;
      hi  = n - 1;
      piv = blk_store[0];
      while (lo <= hi) begin
        while (lo < n && blk_store[lo] < piv) lo++;
        while (hi >= 0 && blk_store[hi] > piv) hi--;
        if (lo <= hi) begin
          tmp           = blk_store[lo];
          blk_store[lo] = blk_store[hi];
          blk_store[hi] = tmp;
          lo++;
          hi--;
        end
      end
      return lo;
    endfunction

    function void note_input(logic [DATA_WIDTH-1:0] value, logic last);
      int           split;
      element_res_t r;
      items_in++;
      // store saturates; a dropped word still closes the block
      if (blk_count < MAX_ELEMENTS) begin
        blk_store[blk_count] = value;
        blk_count++;
      end
      if (!last) return;
      split = partition_block(blk_count);
      for (int k = 0; k < blk_count; k++) begin
        r.value    = blk_store[k];
        r.position = k[IDX_W-1:0];
        r.split    = split[CNT_W-1:0];
        r.last     = (k == blk_count - 1);
        partitioned_q.push_back(r);
      end
      blk_count = 0;
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
      element_res_t exp_r;
      element_res_t got;
      got.value    = tdata[DATA_WIDTH-1:0];
      got.position = tdata[DATA_WIDTH +: IDX_W];
      got.split    = tdata[DATA_WIDTH+IDX_W +: CNT_W];
      got.last     = tlast;
      if (partitioned_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected element: value %0d pos %0d split %0d last %0b",
                   $realtime, got.value, got.position, got.split, got.last);
        return;
      end
      exp_r = partitioned_q.pop_front();
      if (got.value !== exp_r.value || got.position !== exp_r.position ||
          got.split !== exp_r.split || got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10) begin
          $write("[%0t] element differs: exp value %0d pos %0d split %0d last %0b",
                 $realtime, exp_r.value, exp_r.position, exp_r.split, exp_r.last);
          $display(" / got value %0d pos %0d split %0d last %0b",
                   got.value, got.position, got.split, got.last);
        end
      end
    endfunction

    function int pending();
      return partitioned_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [DATA_WIDTH-1:0]   in_tdata = '0;   // [31:0] value
  logic                    in_tlast = 1'b0; // is_last
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;       // [31:0] value_res, [35:32] position,
                                            // [40:36] split_index
  logic                    out_tlast;       // is_last_res

  partition_scoreboard sb = new;
  int                  cycle_count = 0;
  int                  sent = 0;
  int                  burst_left = 0;

  hoare_partition_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hoare_partition_engine_unit: mismatch");
      $finish;
    end
  end

  // both handshakes are observed at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    end
  end

  // Result side: windows of always-ready, a rotating stall pattern, coin flips
  // and mostly-stalled; one long hold-off to back the block up.
  initial begin
    int         mode;
    int         mode_left;
    int         phase;
    logic [7:0] pattern;
    bit         held;
    logic       rdy;
    mode_left = 0;
    phase     = 0;
    pattern   = 8'hff;
    held      = 1'b0;
    mode      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.items_in >= 70) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
        pattern   = 8'($urandom);
      end
      mode_left--;
      phase = (phase + 1) % 8;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = pattern[phase];
        2: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      out_tready <= rdy;
      @(posedge clk);
    end
  end

  // Offer one item and hold it until taken; bursts end in a random gap.
  task automatic send_item(input logic [DATA_WIDTH-1:0] value, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // mix of full-range words, small values with many ties, and extremes
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 8) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single element, most negative value
    send_item(32'h8000_0000, 1'b1);
    // pair of extremes
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    // all equal to the pivot
    repeat (2) send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b1);
    // overfull load: the two extra words are dropped, the flagged one closes the block
    for (int i = 0; i < MAX_ELEMENTS + 2; i++)
      send_item((i % 3 == 0) ? 32'h7fff_ffff : (i % 3 == 1) ? 32'h8000_0000 : i - 8,
                i == MAX_ELEMENTS + 1);

    // random blocks, now and then longer than the store
    while (sent < TARGET_ITEMS) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4)
                                        : $urandom_range(1, MAX_ELEMENTS);
      for (int j = 0; j < len; j++) send_item(pick_value(), j == len - 1);
    end
    in_tvalid <= 1'b0;
    // let the monitor note the final item before looking at the queue
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hoare_partition_engine_unit: match");
    end else begin
      $display("hoare_partition_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
